// ===== hw/rtl/prom_pkg.sv =====
package prom_pkg;

  // Output transforms: four rotations, each with an optional flip
  typedef enum logic [2:0] {
    XF_NORMAL  = 3'd0,
    XF_ROT90   = 3'd1,
    XF_ROT180  = 3'd2,
    XF_ROT270  = 3'd3,
    XF_FLIP    = 3'd4,
    XF_FLIP90  = 3'd5,
    XF_FLIP180 = 3'd6,
    XF_FLIP270 = 3'd7
  } xform_t;

  localparam logic OP_TO_BUFFER = 1'b0;
  localparam logic OP_TO_OUTPUT = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SRC_OUT = 2'd1;
  localparam logic [1:0] ST_DST_OUT = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BUF_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BUF_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_XFORM      = 2'd2;

  localparam int DIM_W = 15;

  typedef struct packed {
    logic               op;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_w;
    logic signed [15:0] rect_h;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_w;
    logic signed [15:0] out_h;
  } out_t;

  // Per-stage load enables from the handshake control
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } adv_t;

  // Inverse transform: only the plain 90 and 270 rotations differ
  function automatic xform_t inv_xform(input xform_t t);
    xform_t r;
    case (t)
      XF_ROT90: r = XF_ROT270;
      XF_ROT270: r = XF_ROT90;
      default: r = t;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/pixel_rect_orientation_mapper_unit.sv =====
// channel  | signals                        | item
// ---------+--------------------------------+------------------------------------
// in       | in_valid / in_ready / in_data  | op + rectangle (prom_pkg::in_t)
// out      | out_valid / out_ready/out_data | status + mapped rect (prom_pkg::out_t)
// cfg      | cfg_we / cfg_index / cfg_data  | register write, no handshake
//
// Three register stages: source check, coordinate mapping, target check.
// One item per cycle sustained while out_ready stays high; items pass stages 1 and 2 before out_valid.
// Stalls propagate back stage by stage; empty stages still load, so bubbles close.
// Reset clears the stage valid bits and sets the buffer to 1x1, normal transform.
module pixel_rect_orientation_mapper_unit #(
  parameter int MAX_EXTENT = 16384
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  prom_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output prom_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [prom_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [prom_pkg::DIM_W-1:0]       cfg_data
);

  logic [prom_pkg::DIM_W-1:0] buf_width, buf_height;
  prom_pkg::xform_t           xform;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_width  <= prom_pkg::DIM_W'(1);
      buf_height <= prom_pkg::DIM_W'(1);
      xform      <= prom_pkg::XF_NORMAL;
    end else if (cfg_we) begin
      case (cfg_index)
        prom_pkg::CFG_BUF_WIDTH:  buf_width  <= cfg_data;
        prom_pkg::CFG_BUF_HEIGHT: buf_height <= cfg_data;
        prom_pkg::CFG_XFORM:      xform      <= prom_pkg::xform_t'(cfg_data[2:0]);
        default: ;
      endcase
    end
  end

  // Stage valid bits; the third stage is the output register
  logic           v1, v2;
  prom_pkg::adv_t adv;

  always_comb begin
    adv.s3 = !out_valid || out_ready;
    adv.s2 = !v2 || adv.s3;
    adv.s1 = !v1 || adv.s2;
  end

  assign in_ready = adv.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv.s1) v1 <= in_valid;
      if (adv.s2) v2 <= v1;
      if (adv.s3) out_valid <= v2;
    end
  end

  prom_datapath #(
    .MAX_EXTENT(MAX_EXTENT)
  ) u_datapath (
    .clk       (clk),
    .adv       (adv),
    .in_data   (in_data),
    .buf_width (buf_width),
    .buf_height(buf_height),
    .xform     (xform),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // failed checks carry a zero rectangle
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != prom_pkg::ST_OK) |->
      (out_data.out_x == '0) && (out_data.out_y == '0)
      && (out_data.out_w == '0) && (out_data.out_h == '0))
    else $error("failed item with nonzero rectangle");

  // a passing item is a non-empty rectangle at a non-negative origin
  a_ok_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == prom_pkg::ST_OK) |->
      !out_data.out_x[15] && !out_data.out_y[15]
      && (out_data.out_w > 0) && (out_data.out_h > 0))
    else $error("passing item with bad rectangle");

  // full pipe with stalled output must hold off the input
  a_full_block: assert property (@(posedge clk) disable iff (rst)
    v1 && v2 && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline full");

  // an item in the second stage reaches the output register when it may load
  a_advance: assert property (@(posedge clk) disable iff (rst)
    v2 && adv.s3 |=> out_valid)
    else $error("item lost between stage 2 and output");
`endif

endmodule

// ===== hw/rtl/prom_datapath.sv =====
module prom_datapath #(
  parameter int MAX_EXTENT = 16384
) (
  input  logic                          clk,
  input  prom_pkg::adv_t                adv,
  input  prom_pkg::in_t                 in_data,
  input  logic [prom_pkg::DIM_W-1:0]    buf_width,
  input  logic [prom_pkg::DIM_W-1:0]    buf_height,
  input  prom_pkg::xform_t              xform,
  output prom_pkg::out_t                out_data
);

  localparam logic [prom_pkg::DIM_W-1:0] SAT = prom_pkg::DIM_W'(MAX_EXTENT);

  // ---------------- stage 1: source check, edge distances ----------------
  logic [prom_pkg::DIM_W-1:0] bw, bh, ow, oh, src_w, src_h, tgt_w, tgt_h;
  logic signed [16:0]         sum_x, sum_y;
  logic signed [17:0]         xr_c, yr_c;
  logic                       src_ok;
  prom_pkg::xform_t           mt_c;

  always_comb begin
    bw = (buf_width > SAT) ? SAT : buf_width;
    bh = (buf_height > SAT) ? SAT : buf_height;
    ow = xform[0] ? bh : bw;
    oh = xform[0] ? bw : bh;
    if (in_data.op == prom_pkg::OP_TO_OUTPUT) begin
      src_w = bw;
      src_h = bh;
      tgt_w = ow;
      tgt_h = oh;
      mt_c  = xform;
    end else begin
      src_w = ow;
      src_h = oh;
      tgt_w = bw;
      tgt_h = bh;
      mt_c  = prom_pkg::inv_xform(xform);
    end
    sum_x = {in_data.rect_x[15], in_data.rect_x} + {in_data.rect_w[15], in_data.rect_w};
    sum_y = {in_data.rect_y[15], in_data.rect_y} + {in_data.rect_h[15], in_data.rect_h};
    src_ok = !in_data.rect_x[15] && !in_data.rect_y[15]
          && !in_data.rect_w[15] && (in_data.rect_w != '0)
          && !in_data.rect_h[15] && (in_data.rect_h != '0)
          && (sum_x <= $signed({2'b00, src_w}))
          && (sum_y <= $signed({2'b00, src_h}));
    xr_c = $signed({3'b000, src_w}) - $signed({{2{in_data.rect_x[15]}}, in_data.rect_x})
         - $signed({{2{in_data.rect_w[15]}}, in_data.rect_w});
    yr_c = $signed({3'b000, src_h}) - $signed({{2{in_data.rect_y[15]}}, in_data.rect_y})
         - $signed({{2{in_data.rect_h[15]}}, in_data.rect_h});
  end

  logic                       s1_ok;
  logic signed [15:0]         s1_x, s1_y, s1_w, s1_h;
  logic signed [17:0]         s1_xr, s1_yr;
  prom_pkg::xform_t           s1_mt;
  logic [prom_pkg::DIM_W-1:0] s1_tw, s1_th;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      s1_ok <= src_ok;
      s1_x  <= in_data.rect_x;
      s1_y  <= in_data.rect_y;
      s1_w  <= in_data.rect_w;
      s1_h  <= in_data.rect_h;
      s1_xr <= xr_c;
      s1_yr <= yr_c;
      s1_mt <= mt_c;
      s1_tw <= tgt_w;
      s1_th <= tgt_h;
    end
  end

  // ---------------- stage 2: coordinate mapping ----------------
  logic signed [17:0] x18, y18, mx_c, my_c;
  logic signed [15:0] mw_c, mh_c;

  always_comb begin
    x18 = {{2{s1_x[15]}}, s1_x};
    y18 = {{2{s1_y[15]}}, s1_y};
    mw_c = s1_mt[0] ? s1_h : s1_w;
    mh_c = s1_mt[0] ? s1_w : s1_h;
    case (s1_mt)
      prom_pkg::XF_NORMAL: begin
        mx_c = x18;    my_c = y18;
      end
      prom_pkg::XF_ROT90: begin
        mx_c = s1_yr;  my_c = x18;
      end
      prom_pkg::XF_ROT180: begin
        mx_c = s1_xr;  my_c = s1_yr;
      end
      prom_pkg::XF_ROT270: begin
        mx_c = y18;    my_c = s1_xr;
      end
      prom_pkg::XF_FLIP: begin
        mx_c = s1_xr;  my_c = y18;
      end
      prom_pkg::XF_FLIP90: begin
        mx_c = y18;    my_c = x18;
      end
      prom_pkg::XF_FLIP180: begin
        mx_c = x18;    my_c = s1_yr;
      end
      default: begin
        mx_c = s1_yr;  my_c = s1_xr;
      end
    endcase
  end

  logic                       s2_ok;
  logic signed [17:0]         s2_x, s2_y;
  logic signed [15:0]         s2_w, s2_h;
  logic [prom_pkg::DIM_W-1:0] s2_tw, s2_th;

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      s2_ok <= s1_ok;
      s2_x  <= mx_c;
      s2_y  <= my_c;
      s2_w  <= mw_c;
      s2_h  <= mh_c;
      s2_tw <= s1_tw;
      s2_th <= s1_th;
    end
  end

  // ---------------- stage 3: target check, status ----------------
  logic signed [18:0] end_x, end_y;
  logic               dst_ok;
  logic [1:0]         status_c;

  always_comb begin
    end_x = {s2_x[17], s2_x} + {{3{s2_w[15]}}, s2_w};
    end_y = {s2_y[17], s2_y} + {{3{s2_h[15]}}, s2_h};
    dst_ok = !s2_x[17] && !s2_y[17]
          && !s2_w[15] && (s2_w != '0)
          && !s2_h[15] && (s2_h != '0)
          && (end_x <= $signed({4'b0000, s2_tw}))
          && (end_y <= $signed({4'b0000, s2_th}));
    if (!s2_ok) begin
      status_c = prom_pkg::ST_SRC_OUT;
    end else if (!dst_ok) begin
      status_c = prom_pkg::ST_DST_OUT;
    end else begin
      status_c = prom_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      out_data.status <= status_c;
      if (status_c == prom_pkg::ST_OK) begin
        out_data.out_x <= s2_x[15:0];
        out_data.out_y <= s2_y[15:0];
        out_data.out_w <= s2_w;
        out_data.out_h <= s2_h;
      end else begin
        out_data.out_x <= '0;
        out_data.out_y <= '0;
        out_data.out_w <= '0;
        out_data.out_h <= '0;
      end
    end
  end

endmodule

// ===== tb/sv/rect_map_checker.sv =====
`timescale 1ns / 100ps

module rect_map_checker #(
  parameter int MAX_EXTENT = 16384
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  prom_pkg::in_t                    in_data,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  prom_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [prom_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [prom_pkg::DIM_W-1:0]       cfg_data,
  output int                               pending_count,
  output int                               fail_count
);

  logic [prom_pkg::DIM_W-1:0] buf_w;
  logic [prom_pkg::DIM_W-1:0] buf_h;
  prom_pkg::xform_t           mode;
  prom_pkg::out_t             expected_rects[$];
  prom_pkg::out_t             want;

  initial begin
    pending_count = 0;
    fail_count = 0;
  end

  function automatic bit fits(int x, int y, int w, int h, int sw, int sh);
    return x >= 0 && y >= 0 && w > 0 && h > 0 && x + w <= sw && y + h <= sh;
  endfunction

  function automatic prom_pkg::out_t predict_mapping(prom_pkg::in_t it,
                                                     logic [prom_pkg::DIM_W-1:0] bw_reg,
                                                     logic [prom_pkg::DIM_W-1:0] bh_reg,
                                                     prom_pkg::xform_t m);
    int               bw, bh, ow, oh, sw, sh, dw, dh;
    int               x, y, w, h, xr, yr, mx, my, mw, mh;
    prom_pkg::xform_t t;
    prom_pkg::out_t   res;
    bw = (bw_reg > MAX_EXTENT) ? MAX_EXTENT : int'(bw_reg);
    bh = (bh_reg > MAX_EXTENT) ? MAX_EXTENT : int'(bh_reg);
    ow = m[0] ? bh : bw;
    oh = m[0] ? bw : bh;
    x = $signed(it.rect_x);
    y = $signed(it.rect_y);
    w = $signed(it.rect_w);
    h = $signed(it.rect_h);
    res = '0;
    if (it.op == prom_pkg::OP_TO_BUFFER) begin
      // oriented space back to buffer: plain 90 and 270 trade places
      case (m)
        prom_pkg::XF_ROT90: t = prom_pkg::XF_ROT270;
        prom_pkg::XF_ROT270: t = prom_pkg::XF_ROT90;
        default: t = m;
      endcase
      sw = ow; sh = oh; dw = bw; dh = bh;
    end else begin
      t = m;
      sw = bw; sh = bh; dw = ow; dh = oh;
    end
    if (!fits(x, y, w, h, sw, sh)) begin
      res.status = prom_pkg::ST_SRC_OUT;
    end else begin
      xr = sw - x - w;
      yr = sh - y - h;
      mw = t[0] ? h : w;
      mh = t[0] ? w : h;
      case (t)
        prom_pkg::XF_NORMAL: begin mx = x; my = y; end
        prom_pkg::XF_ROT90: begin mx = yr; my = x; end
        prom_pkg::XF_ROT180: begin mx = xr; my = yr; end
        prom_pkg::XF_ROT270: begin mx = y; my = xr; end
        prom_pkg::XF_FLIP: begin mx = xr; my = y; end
        prom_pkg::XF_FLIP90: begin mx = y; my = x; end
        prom_pkg::XF_FLIP180: begin mx = x; my = yr; end
        default: begin mx = yr; my = xr; end
      endcase
      if (fits(mx, my, mw, mh, dw, dh)) begin
        res.status = prom_pkg::ST_OK;
        res.out_x = mx[15:0];
        res.out_y = my[15:0];
        res.out_w = mw[15:0];
        res.out_h = mh[15:0];
      end else begin
        res.status = prom_pkg::ST_DST_OUT;
      end
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      buf_w <= prom_pkg::DIM_W'(1);
      buf_h <= prom_pkg::DIM_W'(1);
      mode <= prom_pkg::XF_NORMAL;
      expected_rects.delete();
      pending_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          prom_pkg::CFG_BUF_WIDTH: buf_w <= cfg_data;
          prom_pkg::CFG_BUF_HEIGHT: buf_h <= cfg_data;
          prom_pkg::CFG_XFORM: mode <= prom_pkg::xform_t'(cfg_data[2:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_rects.push_back(predict_mapping(in_data, buf_w, buf_h, mode));
      if (out_valid && out_ready) begin
        if (expected_rects.size() == 0) begin
          $display("%0t: unexpected item, expected none actual %p", $time, out_data);
          fail_count++;
        end else begin
          want = expected_rects.pop_front();
          check_field("status", 16'(want.status), 16'(out_data.status));
          check_field("out_x", want.out_x, out_data.out_x);
          check_field("out_y", want.out_y, out_data.out_y);
          check_field("out_w", want.out_w, out_data.out_w);
          check_field("out_h", want.out_h, out_data.out_h);
        end
      end
      pending_count <= expected_rects.size();
    end
  end

endmodule

// ===== tb/sv/pixel_rect_orientation_mapper_unit_tb.sv =====
`timescale 1ns / 100ps

module pixel_rect_orientation_mapper_unit_tb;

  localparam int MAX_EXTENT = 16384;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BLOCKS = 12;
  localparam int BLOCK_ITEMS = 154;
  // index with no register behind it; writes must be ignored
  localparam logic [prom_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  prom_pkg::in_t                    in_data = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  prom_pkg::out_t                   out_data;
  logic                             cfg_we = 1'b0;
  logic [prom_pkg::CFG_INDEX_W-1:0] cfg_index = prom_pkg::CFG_BUF_WIDTH;
  logic [prom_pkg::DIM_W-1:0]       cfg_data = '0;

  int pending_count;
  int fail_count;
  int cycle_count = 0;
  int src_idle_pct = 26;
  int sink_idle_pct = 57;

  // stimulus-side copy of the registers, used to aim rectangles
  logic [prom_pkg::DIM_W-1:0] cur_bw = prom_pkg::DIM_W'(1);
  logic [prom_pkg::DIM_W-1:0] cur_bh = prom_pkg::DIM_W'(1);
  prom_pkg::xform_t           cur_mode = prom_pkg::XF_NORMAL;

  pixel_rect_orientation_mapper_unit #(
    .MAX_EXTENT(MAX_EXTENT)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  rect_map_checker #(
    .MAX_EXTENT(MAX_EXTENT)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pending_count(pending_count),
    .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pixel_rect_orientation_mapper_unit regression: fail");
      $finish;
    end
  end

  task automatic send_rect(input prom_pkg::in_t it);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_fields(input logic op, input int x, input int y, input int w,
                             input int h);
    prom_pkg::in_t it;
    it.op = op;
    it.rect_x = x[15:0];
    it.rect_y = y[15:0];
    it.rect_w = w[15:0];
    it.rect_h = h[15:0];
    send_rect(it);
  endtask

  // stop sending and wait until every item has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [prom_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [prom_pkg::DIM_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      prom_pkg::CFG_BUF_WIDTH: cur_bw = val;
      prom_pkg::CFG_BUF_HEIGHT: cur_bh = val;
      prom_pkg::CFG_XFORM: cur_mode = prom_pkg::xform_t'(val[2:0]);
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [prom_pkg::DIM_W-1:0] bw,
                            input logic [prom_pkg::DIM_W-1:0] bh,
                            input prom_pkg::xform_t m);
    drain();
    write_reg(prom_pkg::CFG_BUF_WIDTH, bw);
    write_reg(prom_pkg::CFG_BUF_HEIGHT, bh);
    write_reg(prom_pkg::CFG_XFORM, prom_pkg::DIM_W'(m));
  endtask

  function automatic logic [prom_pkg::DIM_W-1:0] pick_extent(int cls);
    case (cls)
      0: return prom_pkg::DIM_W'($urandom_range(1, 12));
      1: return prom_pkg::DIM_W'($urandom_range(1, 300));
      2: begin
        case ($urandom_range(4))
          0: return prom_pkg::DIM_W'(1);
          1: return prom_pkg::DIM_W'(MAX_EXTENT - 1);
          2: return prom_pkg::DIM_W'(MAX_EXTENT);
          3: return prom_pkg::DIM_W'(MAX_EXTENT + 1);
          default: return 15'h7fff;
        endcase
      end
      default: return prom_pkg::DIM_W'($urandom_range(1, 32767));
    endcase
  endfunction

  // start/length inside [0, size), biased toward the edges
  function automatic void pick_span(input int size, output int start, output int len);
    start = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, size - 1);
    len = ($urandom_range(3) == 0) ? size - start : $urandom_range(1, size - start);
  endfunction

  function automatic prom_pkg::in_t random_rect();
    prom_pkg::in_t it;
    int            bw, bh, sw, sh, x, y, w, h, pick;
    it.op = 1'($urandom_range(1));
    bw = (cur_bw > MAX_EXTENT) ? MAX_EXTENT : int'(cur_bw);
    bh = (cur_bh > MAX_EXTENT) ? MAX_EXTENT : int'(cur_bh);
    if (it.op == prom_pkg::OP_TO_BUFFER && cur_mode[0]) begin
      sw = bh;
      sh = bw;
    end else begin
      sw = bw;
      sh = bh;
    end
    pick = $urandom_range(99);
    if (pick < 15 || sw == 0 || sh == 0) begin
      it.rect_x = 16'($urandom);
      it.rect_y = 16'($urandom);
      it.rect_w = 16'($urandom);
      it.rect_h = 16'($urandom);
    end else begin
      pick_span(sw, x, w);
      pick_span(sh, y, h);
      // a tenth or so just off the source space
      if (pick < 27) begin
        case ($urandom_range(3))
          0: x = x - $urandom_range(1, 3);
          1: y = y - $urandom_range(1, 3);
          2: w = (x + w == sw) ? w + 1 : -w;
          default: h = (y + h == sh) ? h + 1 : 0;
        endcase
      end
      it.rect_x = x[15:0];
      it.rect_y = y[15:0];
      it.rect_w = w[15:0];
      it.rect_h = h[15:0];
    end
    return it;
  endfunction

  initial begin
    int blk;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // 1x1 buffer from reset
    send_fields(prom_pkg::OP_TO_BUFFER, 0, 0, 1, 1);
    send_fields(prom_pkg::OP_TO_OUTPUT, 0, 0, 1, 1);
    send_fields(prom_pkg::OP_TO_OUTPUT, 0, 0, 2, 1);
    send_fields(prom_pkg::OP_TO_BUFFER, -32768, -32768, -32768, -32768);
    send_fields(prom_pkg::OP_TO_OUTPUT, 32767, 32767, 32767, 32767);
    send_fields(prom_pkg::OP_TO_BUFFER, 0, 0, 0, 1);
    send_fields(prom_pkg::OP_TO_OUTPUT, 0, 0, 1, -1);

    // zero width: nothing fits; stray index must not disturb anything
    drain();
    write_reg(prom_pkg::CFG_BUF_WIDTH, prom_pkg::DIM_W'(0));
    write_reg(CFG_UNUSED, 15'h7fff);
    send_fields(prom_pkg::OP_TO_OUTPUT, 0, 0, 1, 1);
    send_fields(prom_pkg::OP_TO_BUFFER, 0, 0, 1, 1);

    // oversized registers saturate to the max extent
    set_config(15'h7fff, prom_pkg::DIM_W'(MAX_EXTENT + 1), prom_pkg::XF_FLIP90);
    send_fields(prom_pkg::OP_TO_BUFFER, 0, 0, MAX_EXTENT, MAX_EXTENT);
    send_fields(prom_pkg::OP_TO_OUTPUT, MAX_EXTENT - 1, 0, 1, MAX_EXTENT);
    send_fields(prom_pkg::OP_TO_OUTPUT, 0, 0, MAX_EXTENT + 1, 1);

    // every transform once on a 5x3 buffer
    set_config(prom_pkg::DIM_W'(5), prom_pkg::DIM_W'(3), prom_pkg::XF_NORMAL);
    for (int m = 0; m < 8; m++) begin
      drain();
      write_reg(prom_pkg::CFG_XFORM, prom_pkg::DIM_W'(m));
      send_fields(m[0], 1, 0, 2, 1);
    end

    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      if (blk == RANDOM_BLOCKS / 3) begin
        src_idle_pct = 57;
        sink_idle_pct = 26;
      end else if (blk == 2 * RANDOM_BLOCKS / 3) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      set_config(pick_extent(blk % 4), pick_extent((blk + 1) % 4),
                 (blk < 8) ? prom_pkg::xform_t'(blk[2:0])
                           : prom_pkg::xform_t'(3'($urandom_range(7))));
      repeat (BLOCK_ITEMS) send_rect(random_rect());
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("pixel_rect_orientation_mapper_unit regression: pass");
    end else begin
      $display("pixel_rect_orientation_mapper_unit regression: fail");
    end
    $finish;
  end

endmodule
